// ----- rtl/core/ilir_pkg.sv -----
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared types and codes for the indexed list with insert and remove.
// ----------------------------------------------------------------------------
package ilir_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned POS_W        = 7;

  typedef logic [1:0] action_t;
  typedef logic [1:0] status_t;

  localparam action_t ACT_INSERT = 2'd0;
  localparam action_t ACT_REMOVE = 2'd1;
  localparam action_t ACT_READ   = 2'd2;

  localparam status_t ST_DONE = 2'd0;
  localparam status_t ST_BAD  = 2'd1;
  localparam status_t ST_FULL = 2'd2;

  // Broadcast from the control to every cell of the row.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [POS_W-1:0] pos;
  } ilir_ctrl_t;

endpackage

// ----- rtl/core/ilir_cell.sv -----
// ----------------------------------------------------------------------------
// ilir_cell
// One list slot: holds its word and takes a neighbor's word or the new
// word when the row shifts around an insert or a remove.
// ----------------------------------------------------------------------------
module ilir_cell #(
  parameter int unsigned CmpW = 7,
  parameter int unsigned Idx  = 0
) (
  input  logic                                clk_i,
  input  ilir_pkg::ilir_ctrl_t                ctrl_i,
  input  logic [ilir_pkg::DATA_W-1:0]         value_i,
  input  logic [ilir_pkg::DATA_W-1:0]         lower_i,
  input  logic [ilir_pkg::DATA_W-1:0]         upper_i,
  output logic [ilir_pkg::DATA_W-1:0]         entry_o
);
  import ilir_pkg::*;

  localparam logic [CmpW-1:0] IdxV = CmpW'(Idx);

  logic [DATA_W-1:0] entry_q, entry_d;
  logic [CmpW-1:0]   pos;

  assign pos = CmpW'(ctrl_i.pos);

  always_comb begin
    entry_d = entry_q;
    priority if (ctrl_i.ins && IdxV == pos) begin
      entry_d = value_i;
    end else if (ctrl_i.ins && IdxV > pos) begin
      // shift up: take the word from the slot below
      entry_d = lower_i;
    end else if (ctrl_i.rem && IdxV >= pos) begin
      // shift down: take the word from the slot above
      entry_d = upper_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ----- rtl/core/indexed_list_insert_remove.sv -----
// ----------------------------------------------------------------------------
// indexed_list_insert_remove
// Bounded ordered list of 32-bit words with insert, remove and read by
// position.
// ----------------------------------------------------------------------------
// Input channel: action_i, position_i, value_in_i, qualified by in_valid_i;
// a word is taken on a clock edge with in_valid_i high and in_stall_o low.
// Output channel: status_o, value_out_o, entry_count_o, qualified by
// out_valid_o; the receiver holds it with out_stall_i.
// Each accepted word gives exactly one result word, in the next cycle.
// Throughput is one word per cycle unless stalled: the list lives in a row
// of cells, one per slot, and all slots at or past the position shift in
// the same cycle as the word is taken. A read selects one slot of the row.
// Insert takes positions 0 to the count, remove and read positions below
// the count; anything else reports a bad position, an insert at a good
// position on a full list reports full; a failed action changes nothing.
// While a result waits under stall, in_stall_o is high and the result
// holds. Reset empties the list and drops any pending result; slot
// contents are not cleared, as only slots below the count are ever read.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove #(
  parameter int unsigned CAPACITY = ilir_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ilir_pkg::action_t                   action_i,
  input  logic [ilir_pkg::POS_W-1:0]          position_i,
  input  logic signed [ilir_pkg::DATA_W-1:0]  value_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ilir_pkg::status_t                   status_o,
  output logic signed [ilir_pkg::DATA_W-1:0]  value_out_o,
  output logic [ilir_pkg::POS_W-1:0]          entry_count_o
);
  import ilir_pkg::*;

  localparam int unsigned CountW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW   = (CountW > POS_W) ? CountW : POS_W;
  localparam int unsigned AddrW  = $clog2(CAPACITY);

  logic [CountW-1:0] count_q, count_d;
  logic              out_valid_q;
  status_t           status_q, status_d;
  logic [DATA_W-1:0] value_q, value_d;
  logic [POS_W-1:0]  ecount_q;

  logic              accept;
  logic [CmpW-1:0]   pos_c, cnt_c;
  logic              pos_in, pos_ins_ok, full;
  ilir_ctrl_t        ctrl;
  logic [DATA_W-1:0] entry [CAPACITY];
  logic [DATA_W-1:0] rd_word;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign pos_c      = CmpW'(position_i);
  assign cnt_c      = CmpW'(count_q);
  assign pos_in     = pos_c < cnt_c;
  assign pos_ins_ok = pos_c <= cnt_c;
  assign full       = cnt_c >= CmpW'(CAPACITY);

  assign ctrl.ins = accept && (action_i == ACT_INSERT) && pos_ins_ok && !full;
  assign ctrl.rem = accept && (action_i == ACT_REMOVE) && pos_in;
  assign ctrl.pos = position_i;

  // Row of slots; each hands its word to its neighbors.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] lower, upper;
    if (g == 0) begin : g_first
      assign lower = value_in_i;
    end else begin : g_mid
      assign lower = entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign upper = entry[g];
    end else begin : g_top
      assign upper = entry[g+1];
    end
    ilir_cell #(
      .CmpW (CmpW),
      .Idx  (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .value_i (value_in_i),
      .lower_i (lower),
      .upper_i (upper),
      .entry_o (entry[g])
    );
  end

  // pos_in implies the position is below CAPACITY, so the low bits index.
  assign rd_word = entry[pos_c[AddrW-1:0]];

  always_comb begin
    count_d  = count_q;
    status_d = ST_BAD;
    value_d  = '0;
    unique case (action_i)
      ACT_INSERT: begin
        priority if (!pos_ins_ok) begin
          status_d = ST_BAD;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_DONE;
          count_d  = count_q + CountW'(1);
        end
      end
      ACT_REMOVE: begin
        if (pos_in) begin
          status_d = ST_DONE;
          value_d  = rd_word;
          count_d  = count_q - CountW'(1);
        end
      end
      ACT_READ: begin
        if (pos_in) begin
          status_d = ST_DONE;
          value_d  = rd_word;
        end
      end
      default: begin
        status_d = ST_BAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      value_q  <= value_d;
      ecount_q <= POS_W'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign value_out_o   = $signed(value_q);
  assign entry_count_o = ecount_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_c <= CmpW'(CAPACITY))
    else $error("entry count above capacity");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> count_q == $past(count_q) + CountW'(1))
    else $error("insert did not advance the count");

  a_rem_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.rem |=> count_q == $past(count_q) - CountW'(1))
    else $error("remove did not drop the count");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != ST_DONE |-> value_q == '0)
    else $error("failed action returned a nonzero word");

endmodule
